### design/q2e_pkg.sv
package q2e_pkg;

  localparam int TW = 34;
  localparam int CW = 36;
  localparam int ZW = 36;
  localparam int NW = 62;
  localparam int SQ_STEPS = 31;
  localparam int ATAN_LEN = 24;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam longint ATAN_TAB [ATAN_LEN] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] yaw_angle;
    logic               sine_clamped;
  } euler_t;

  typedef struct packed {
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    logic signed [31:0]   t2;
    logic signed [TW-1:0] t3;
    logic signed [TW-1:0] t4;
    logic                 clamped;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 done;
  } cord_t;

  // lane 2 pitch, lane 1 roll, lane 0 yaw
  typedef struct packed {
    cord_t [2:0] lane;
    logic        clamped;
  } cstage_t;

  function automatic cord_t cordic_init(input logic signed [CW-1:0] y,
                                        input logic signed [CW-1:0] x);
    cord_t c;
    c.x = x;
    c.y = y;
    c.z = '0;
    c.done = 1'b0;
    if (y == '0) begin
      c.done = 1'b1;
      c.z = (x < 0) ? ZW'(PI_Q30) : ZW'(0);
    end else if (x == '0) begin
      c.done = 1'b1;
      c.z = (y > 0) ? ZW'(HALF_PI_Q30) : -ZW'(HALF_PI_Q30);
    end else if (x < 0) begin
      c.z = (y > 0) ? ZW'(PI_Q30) : -ZW'(PI_Q30);
      c.x = -x;
      c.y = -y;
    end
    return c;
  endfunction

endpackage

### design/q2e_sqrt_cell.sv
module q2e_sqrt_cell #(
  parameter int BIT_POS = 60
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [q2e_pkg::NW-1:0]  n_i,
  input  logic [q2e_pkg::NW-1:0]  r_i,
  input  q2e_pkg::side_t          side_i,
  output logic                    valid_o,
  output logic [q2e_pkg::NW-1:0]  n_o,
  output logic [q2e_pkg::NW-1:0]  r_o,
  output q2e_pkg::side_t          side_o
);

  localparam logic [q2e_pkg::NW-1:0] BIT = q2e_pkg::NW'(1) << BIT_POS;

  logic [q2e_pkg::NW-1:0] trial;
  logic [q2e_pkg::NW-1:0] n_d, r_d;
  logic                   valid_q;
  logic [q2e_pkg::NW-1:0] n_q, r_q;
  q2e_pkg::side_t         side_q;

  always_comb begin
    trial = r_i + BIT;
    if (n_i >= trial) begin
      n_d = n_i - trial;
      r_d = (r_i >> 1) + BIT;
    end else begin
      n_d = n_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
      r_q <= r_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign n_o = n_q;
  assign r_o = r_q;
  assign side_o = side_q;

endmodule

### design/q2e_cordic_cell.sv
module q2e_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  q2e_pkg::cstage_t  data_i,
  output logic              valid_o,
  output q2e_pkg::cstage_t  data_o
);

  localparam logic signed [q2e_pkg::ZW-1:0] ATAN = q2e_pkg::ZW'(q2e_pkg::ATAN_TAB[IDX]);

  q2e_pkg::cstage_t data_d, data_q;
  logic             valid_q;

  always_comb begin
    logic signed [q2e_pkg::CW-1:0] xs, ys;
    data_d = data_i;
    for (int l = 0; l < 3; l++) begin
      xs = data_i.lane[l].x >>> IDX;
      ys = data_i.lane[l].y >>> IDX;
      if (!data_i.lane[l].done) begin
        if (data_i.lane[l].y > 0) begin
          data_d.lane[l].x = data_i.lane[l].x + ys;
          data_d.lane[l].y = data_i.lane[l].y - xs;
          data_d.lane[l].z = data_i.lane[l].z + ATAN;
        end else begin
          data_d.lane[l].x = data_i.lane[l].x - ys;
          data_d.lane[l].y = data_i.lane[l].y + xs;
          data_d.lane[l].z = data_i.lane[l].z - ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

### design/quaternion_to_euler_core.sv
// quaternion to euler angle converter
// input channel in_valid_i / in_stall_o carries one quaternion (w, x, y, z) in
// q1.15 per transaction; output channel out_valid_o / out_stall_i carries pitch,
// roll and yaw in radians with ANGLE_FRAC_BITS fraction bits plus a clamp flag.
// one result transaction per input transaction, in order.
// pipeline: three registers for products, terms and the square of the sine
// term, 31 square root cells (one result bit each), one cordic setup
// register, CORDIC_STAGES cordic cells and one output register.
// throughput is one transaction per cycle when not stalled; every stage is a
// register that moves forward as the chain advances, so a new quaternion can enter each time.
// when the output register holds a result and out_stall_i is high, the whole
// chain holds and in_stall_o goes high in the same cycle; otherwise the chain
// advances, bubbles included.
// reset clears all valid bits; no results are pending after reset and the
// block accepts a transaction in the first cycle after reset.
module quaternion_to_euler_core #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  q2e_pkg::quat_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output q2e_pkg::euler_t  out_data_o
);

  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam longint HALF_L = longint'(1) << (SH - 1);
  localparam logic signed [q2e_pkg::ZW-1:0] HALF = q2e_pkg::ZW'(HALF_L);
  localparam logic signed [q2e_pkg::ZW-1:0] LIM_PI =
    q2e_pkg::ZW'((q2e_pkg::PI_Q30 + HALF_L) >>> SH);
  localparam logic signed [q2e_pkg::ZW-1:0] LIM_HPI =
    q2e_pkg::ZW'((q2e_pkg::HALF_PI_Q30 + HALF_L) >>> SH);
  localparam int TW = q2e_pkg::TW;
  localparam int NW = q2e_pkg::NW;
  localparam int NS = q2e_pkg::SQ_STEPS;

  typedef struct packed {
    logic signed [31:0] yy, zz, xy, wz, xz, wy, yz, wx, xx;
  } prod_t;

  logic adv;
  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // products
  prod_t p_d, p_q;
  logic  v1_q;

  always_comb begin
    p_d.yy = in_data_i.quat_y * in_data_i.quat_y;
    p_d.zz = in_data_i.quat_z * in_data_i.quat_z;
    p_d.xy = in_data_i.quat_x * in_data_i.quat_y;
    p_d.wz = in_data_i.quat_w * in_data_i.quat_z;
    p_d.xz = in_data_i.quat_x * in_data_i.quat_z;
    p_d.wy = in_data_i.quat_w * in_data_i.quat_y;
    p_d.yz = in_data_i.quat_y * in_data_i.quat_z;
    p_d.wx = in_data_i.quat_w * in_data_i.quat_x;
    p_d.xx = in_data_i.quat_x * in_data_i.quat_x;
  end

  // terms and clamp
  q2e_pkg::side_t t_d, t_q;
  logic           v2_q;

  always_comb begin
    logic signed [TW-1:0] t2raw;
    t_d.t0 = TW'(q2e_pkg::ONE_Q30) - ((TW'(p_q.yy) + TW'(p_q.zz)) <<< 1);
    t_d.t1 = (TW'(p_q.xy) - TW'(p_q.wz)) <<< 1;
    t_d.t3 = (TW'(p_q.yz) - TW'(p_q.wx)) <<< 1;
    t_d.t4 = TW'(q2e_pkg::ONE_Q30) - ((TW'(p_q.xx) + TW'(p_q.yy)) <<< 1);
    t2raw = -((TW'(p_q.xz) + TW'(p_q.wy)) <<< 1);
    t_d.clamped = 1'b0;
    if (t2raw > TW'(q2e_pkg::ONE_Q30)) begin
      t_d.t2 = 32'(q2e_pkg::ONE_Q30);
      t_d.clamped = 1'b1;
    end else if (t2raw < -TW'(q2e_pkg::ONE_Q30)) begin
      t_d.t2 = -32'(q2e_pkg::ONE_Q30);
      t_d.clamped = 1'b1;
    end else begin
      t_d.t2 = t2raw[31:0];
    end
  end

  // radicand 2^60 - t2^2
  logic [NW-1:0]  n_d, n_q;
  q2e_pkg::side_t t3_q;
  logic           v3_q;

  always_comb begin
    logic [31:0] mag;
    logic [NW-1:0] sq;
    mag = (t_q.t2 < 0) ? 32'(-t_q.t2) : 32'(t_q.t2);
    sq = NW'(mag[30:0]) * NW'(mag[30:0]);
    n_d = (NW'(1) << 60) - sq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q <= p_d;
      t_q <= t_d;
      n_q <= n_d;
      t3_q <= t_q;
    end
  end

  // square root chain
  logic           sq_valid [NS+1];
  logic [NW-1:0]  sq_n [NS+1];
  logic [NW-1:0]  sq_r [NS+1];
  q2e_pkg::side_t sq_side [NS+1];

  assign sq_valid[0] = v3_q;
  assign sq_n[0] = n_q;
  assign sq_r[0] = '0;
  assign sq_side[0] = t3_q;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    q2e_sqrt_cell #(
      .BIT_POS(60 - 2 * k)
    ) u_cell (
      .clk_i(clk_i),
      .rst_ni(rst_ni),
      .en_i(adv),
      .valid_i(sq_valid[k]),
      .n_i(sq_n[k]),
      .r_i(sq_r[k]),
      .side_i(sq_side[k]),
      .valid_o(sq_valid[k+1]),
      .n_o(sq_n[k+1]),
      .r_o(sq_r[k+1]),
      .side_o(sq_side[k+1])
    );
  end

  // cordic setup
  q2e_pkg::cstage_t pre_d;
  logic             cd_valid [CORDIC_STAGES+1];
  q2e_pkg::cstage_t cd_data [CORDIC_STAGES+1];
  logic             pre_valid_q;
  q2e_pkg::cstage_t pre_q;

  always_comb begin
    q2e_pkg::side_t s;
    logic signed [q2e_pkg::CW-1:0] c;
    s = sq_side[NS];
    c = q2e_pkg::CW'({1'b0, sq_r[NS][30:0]});
    pre_d.lane[2] = q2e_pkg::cordic_init(q2e_pkg::CW'(s.t2), c);
    pre_d.lane[1] = q2e_pkg::cordic_init(q2e_pkg::CW'(s.t3), q2e_pkg::CW'(s.t4));
    pre_d.lane[0] = q2e_pkg::cordic_init(q2e_pkg::CW'(s.t1), q2e_pkg::CW'(s.t0));
    pre_d.clamped = s.clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (adv) begin
      pre_valid_q <= sq_valid[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pre_q <= pre_d;
    end
  end

  assign cd_valid[0] = pre_valid_q;
  assign cd_data[0] = pre_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    q2e_cordic_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i(clk_i),
      .rst_ni(rst_ni),
      .en_i(adv),
      .valid_i(cd_valid[i]),
      .data_i(cd_data[i]),
      .valid_o(cd_valid[i+1]),
      .data_o(cd_data[i+1])
    );
  end

  // rounding and saturation
  q2e_pkg::euler_t out_d, out_q;
  logic            out_valid_q;

  always_comb begin
    logic signed [q2e_pkg::ZW-1:0] v [3];
    for (int l = 0; l < 3; l++) begin
      v[l] = (cd_data[CORDIC_STAGES].lane[l].z + HALF) >>> SH;
    end
    if (v[2] > LIM_HPI) v[2] = LIM_HPI;
    if (v[2] < -LIM_HPI) v[2] = -LIM_HPI;
    for (int l = 0; l < 2; l++) begin
      if (v[l] > LIM_PI) v[l] = LIM_PI;
      if (v[l] < -LIM_PI) v[l] = -LIM_PI;
    end
    out_d.pitch_angle = v[2][14:0];
    out_d.roll_angle = v[1][15:0];
    out_d.yaw_angle = v[0][15:0];
    out_d.sine_clamped = cd_data[CORDIC_STAGES].clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cd_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

### design/q2e_checker.sv
module q2e_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input q2e_pkg::euler_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_back_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output stalled");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");

endmodule

bind quaternion_to_euler_core q2e_checker u_q2e_checker (.*);
